/* design/rcpwm_pkg.sv */
package rcpwm_pkg;

  localparam int unsigned DefaultChannels = 6;

  localparam int unsigned ChanW  = 3;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ValW   = 16;
  localparam int unsigned DirW   = 2;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [ValW-1:0] NeutralReset = 16'd1500;
  localparam logic [ValW-1:0] MarginReset  = 16'd20;
  localparam logic [ValW-1:0] MinReset     = 16'd1000;
  localparam logic [ValW-1:0] MaxReset     = 16'd2000;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [DirW-1:0] {
    DIR_MIDDLE = 2'd0,
    DIR_INC    = 2'd1,
    DIR_DEC    = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    REG_NEUTRAL = 2'd0,
    REG_MARGIN  = 2'd1,
    REG_MIN     = 2'd2,
    REG_MAX     = 2'd3
  } reg_e;

  typedef struct packed {
    logic             opcode;
    logic [ChanW-1:0] channel;
    logic             pin_level;
    logic [TimeW-1:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [DirW-1:0]  direction;
    logic [ValW-1:0]  stick_value;
    logic [TimeW-1:0] raw_width;
    logic             was_fresh;
  } out_item_t;

  typedef struct packed {
    logic [ValW-1:0] neutral_width;
    logic [ValW-1:0] dead_margin;
    logic [ValW-1:0] min_width;
    logic [ValW-1:0] max_width;
  } cfg_t;

  typedef struct packed {
    dir_e            dir;
    logic [ValW-1:0] value;
  } class_t;

  // Ordered overrides: deadband, then snap to max, then snap to min.
  // Sums are widened so none of the compares can wrap.
  function automatic class_t classify(input logic [TimeW-1:0] w, input cfg_t cfg);
    class_t          res;
    logic [ValW:0]   n_plus_m;
    logic [ValW:0]   min_plus_m;
    logic [TimeW:0]  w_plus_m;
    n_plus_m   = {1'b0, cfg.neutral_width} + {1'b0, cfg.dead_margin};
    min_plus_m = {1'b0, cfg.min_width} + {1'b0, cfg.dead_margin};
    w_plus_m   = {1'b0, w} + (TimeW+1)'(cfg.dead_margin);
    res.dir   = DIR_MIDDLE;
    res.value = cfg.neutral_width;
    if (w > TimeW'(n_plus_m)) begin
      res.dir   = DIR_INC;
      res.value = w[ValW-1:0];
    end else if (w_plus_m < (TimeW+1)'(cfg.neutral_width)) begin
      res.dir   = DIR_DEC;
      res.value = w[ValW-1:0];
    end
    if (w_plus_m >= (TimeW+1)'(cfg.max_width)) begin
      res.dir   = DIR_INC;
      res.value = cfg.max_width;
    end
    if (w <= TimeW'(min_plus_m)) begin
      res.dir   = DIR_DEC;
      res.value = cfg.min_width;
    end
    return res;
  endfunction

endpackage

/* design/rc_pwm_capture_classifier_unit.sv */
// RC pulse-width capture and stick classifier. Edge words (opcode edge) record a
// channel's start time on a rising level and its width, start subtracted from the
// timestamp modulo 2^32, on a falling level, marking the channel fresh; they give
// no result. Read words return the stored width, the fresh mark (then cleared)
// and a direction/value from the neutral deadband and min/max snapping. One word
// is taken every cycle while the input is not stalled; a read word's result goes
// from the input register through the per-channel register file read and the
// classifier compares into the output register. A stalled result holds the next
// read word in the input register and so stalls the input; edge words still pass.
// Channels at or above CHANNELS are ignored on edges and read back as all zero.
// Registers via the APB port: 0x0 neutral, 0x4 margin, 0x8 min, 0xC max, low
// 16 bits; write only when idle.
module rc_pwm_capture_classifier_unit #(
  parameter int unsigned CHANNELS = rcpwm_pkg::DefaultChannels
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  rcpwm_pkg::in_item_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rcpwm_pkg::out_item_t             out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rcpwm_pkg::AddrW-1:0]      paddr,
  input  logic [rcpwm_pkg::DataW-1:0]      pwdata,
  output logic [rcpwm_pkg::DataW-1:0]      prdata,
  output logic                             pready
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  rcpwm_pkg::cfg_t cfg_q;

  logic                    s1_valid_q;
  rcpwm_pkg::in_item_t     s1_q;
  logic                    out_valid_q;
  rcpwm_pkg::out_item_t    out_q;

  logic [rcpwm_pkg::TimeW-1:0] start_q [CHANNELS];
  logic [rcpwm_pkg::TimeW-1:0] width_q [CHANNELS];
  logic [CHANNELS-1:0]         fresh_q;

  logic                    s1_ok, s1_is_read, s1_adv, in_ready, in_fire, cfg_wr;
  logic [IdxW-1:0]         s1_idx;
  rcpwm_pkg::class_t       cls;
  rcpwm_pkg::out_item_t    res;

  // ---------------- configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neutral_width <= rcpwm_pkg::NeutralReset;
      cfg_q.dead_margin   <= rcpwm_pkg::MarginReset;
      cfg_q.min_width     <= rcpwm_pkg::MinReset;
      cfg_q.max_width     <= rcpwm_pkg::MaxReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        rcpwm_pkg::REG_NEUTRAL: cfg_q.neutral_width <= pwdata[rcpwm_pkg::ValW-1:0];
        rcpwm_pkg::REG_MARGIN:  cfg_q.dead_margin   <= pwdata[rcpwm_pkg::ValW-1:0];
        rcpwm_pkg::REG_MIN:     cfg_q.min_width     <= pwdata[rcpwm_pkg::ValW-1:0];
        rcpwm_pkg::REG_MAX:     cfg_q.max_width     <= pwdata[rcpwm_pkg::ValW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rcpwm_pkg::REG_NEUTRAL: prdata = rcpwm_pkg::DataW'(cfg_q.neutral_width);
      rcpwm_pkg::REG_MARGIN:  prdata = rcpwm_pkg::DataW'(cfg_q.dead_margin);
      rcpwm_pkg::REG_MIN:     prdata = rcpwm_pkg::DataW'(cfg_q.min_width);
      rcpwm_pkg::REG_MAX:     prdata = rcpwm_pkg::DataW'(cfg_q.max_width);
      default:                prdata = '0;
    endcase
  end

  // ---------------- handshake
  // Edge words retire from stage 1 without touching the output register.
  assign s1_is_read = (s1_q.opcode == rcpwm_pkg::OP_READ);
  assign s1_adv     = s1_valid_q & (!s1_is_read | !out_valid_q | !out_stall_i);
  assign in_ready   = !s1_valid_q | s1_adv;
  assign in_stall_o = !in_ready;
  assign in_fire    = in_valid_i & in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
  end

  // ---------------- stage 1: register file and classifier
  assign s1_ok  = (32'(s1_q.channel) < CHANNELS);
  assign s1_idx = IdxW'(s1_q.channel);
  assign cls    = rcpwm_pkg::classify(width_q[s1_idx], cfg_q);

  always_comb begin
    res = '0;
    if (s1_ok) begin
      res.direction   = cls.dir;
      res.stick_value = cls.value;
      res.raw_width   = width_q[s1_idx];
      res.was_fresh   = fresh_q[s1_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        start_q[i] <= '0;
        width_q[i] <= '0;
      end
      fresh_q <= '0;
    end else if (s1_adv && s1_ok) begin
      if (s1_is_read) begin
        fresh_q[s1_idx] <= 1'b0;
      end else if (s1_q.pin_level) begin
        start_q[s1_idx] <= s1_q.timestamp_us;
      end else begin
        width_q[s1_idx] <= s1_q.timestamp_us - start_q[s1_idx];
        fresh_q[s1_idx] <= 1'b1;
      end
    end
  end

  // ---------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_is_read) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_is_read) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_read_clears_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_is_read && s1_ok |=> !fresh_q[$past(s1_idx)])
    else $error("fresh mark not cleared by read");

  a_fall_sets_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !s1_is_read && s1_ok && !s1_q.pin_level |=> fresh_q[$past(s1_idx)])
    else $error("falling edge did not mark channel fresh");

  a_bad_chan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_is_read && !s1_ok |=> out_valid_q && (out_q == '0))
    else $error("out-of-range read gave non-zero word");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && !(s1_adv && s1_is_read) |=> !out_valid_q)
    else $error("taken result word repeated");
`endif

endmodule
